FILE: sv/kpc_pkg.sv
// kpc_pkg: shared widths, reset values, event kinds and register indexes
// for the key tap and press classifier
// no dependencies
`default_nettype none

package kpc_pkg;

    // field widths
    localparam int KEY_W   = 5;
    localparam int TICK_W  = 32;
    localparam int COUNT_W = 2;
    localparam int THR_W   = 16;
    localparam int CIDX_W  = 8;

    // packed bus widths
    localparam int S_DATA_W = 40;
    localparam int M_DATA_W = 72;

    // default number of keys
    localparam int KEY_COUNT_DEF = 32;

    // threshold reset values
    localparam logic [THR_W-1:0] TAP_THR_RST    = 16'd300;
    localparam logic [THR_W-1:0] LONG_THR_RST   = 16'd500;
    localparam logic [THR_W-1:0] DBL_WIN_RST    = 16'd400;
    localparam logic [THR_W-1:0] HOLD_THR_RST   = 16'd1000;

    // tap counts
    localparam logic [COUNT_W-1:0] COUNT_NONE   = 2'd0;
    localparam logic [COUNT_W-1:0] COUNT_SINGLE = 2'd1;
    localparam logic [COUNT_W-1:0] COUNT_DOUBLE = 2'd2;

    typedef enum logic [2:0] {
        KIND_KEY_DOWN     = 3'd0,
        KIND_DOUBLE_TAP   = 3'd1,
        KIND_KEY_UP       = 3'd2,
        KIND_TAP          = 3'd3,
        KIND_LONG_TAP     = 3'd4,
        KIND_HOLD_RELEASE = 3'd5
    } kind_t;

    typedef enum logic [CIDX_W-1:0] {
        CFG_TAP_THR  = 8'd0,
        CFG_LONG_THR = 8'd1,
        CFG_DBL_WIN  = 8'd2,
        CFG_HOLD_THR = 8'd3
    } cfg_idx_t;

endpackage

`default_nettype wire

FILE: sv/key_tap_press_classifier.sv
// key_tap_press_classifier: sorts key press and release words into tap events
// using per-key press and tap times held in two synchronous memories
// depends on kpc_pkg
//
//  channel  | direction | payload
//  ---------+-----------+-------------------------------------------------
//  s_       | in        | tdata {now_ticks, key_index}, tuser pressed
//  m_       | out       | tdata {event_time, duration, count, key}, tuser kind
//  cfg_     | in        | cfg_index register, cfg_data 16-bit value
//
// one word per cycle sustained while the output is not stalled; the memory read and the
// read stage are registered at the accepting edge, and the output register then holds the result
// back-to-back words for the same key are served by forwarding the write-back
// reset clears the per-key valid bits at once, so no clearing pass is needed
// a stalled output holds the read stage, and the input stalls behind it
`default_nettype none

module key_tap_press_classifier #(
    parameter int KEY_COUNT = kpc_pkg::KEY_COUNT_DEF
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    // input words
    input  wire logic                         s_tvalid,
    output logic                              s_tready,
    input  wire logic [kpc_pkg::S_DATA_W-1:0] s_tdata,  // key_index[4:0], now_ticks[36:5]
    input  wire logic                         s_tuser,  // pressed[0]
    // result words
    output logic                              m_tvalid,
    input  wire logic                         m_tready,
    output logic [kpc_pkg::M_DATA_W-1:0]      m_tdata,  // event_key[4:0], press_count[6:5],
                                                        // duration_ticks[38:7],
                                                        // event_time[70:39]
    output logic [2:0]                        m_tuser,  // event_kind[2:0]
    // configuration writes
    input  wire logic                         cfg_valid,
    output logic                              cfg_ready,
    input  wire logic [kpc_pkg::CIDX_W-1:0]   cfg_index,
    input  wire logic [kpc_pkg::THR_W-1:0]    cfg_data
);
    import kpc_pkg::*;

    localparam int IDX_W  = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1;
    localparam int WIDE_W = KEY_W + IDX_W;

    // configuration registers
    logic [THR_W-1:0] tap_thr_reg, long_thr_reg, dbl_win_reg, hold_thr_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tap_thr_reg  <= TAP_THR_RST;
            long_thr_reg <= LONG_THR_RST;
            dbl_win_reg  <= DBL_WIN_RST;
            hold_thr_reg <= HOLD_THR_RST;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_TAP_THR:  tap_thr_reg  <= cfg_data;
                CFG_LONG_THR: long_thr_reg <= cfg_data;
                CFG_DBL_WIN:  dbl_win_reg  <= cfg_data;
                CFG_HOLD_THR: hold_thr_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // input word unpacking
    logic [KEY_W-1:0]  in_key;
    logic [TICK_W-1:0] in_now;
    logic [WIDE_W-1:0] in_key_wide;
    logic [IDX_W-1:0]  in_addr;
    logic              in_range;
    logic              accept;

    assign in_key      = s_tdata[KEY_W-1:0];
    assign in_now      = s_tdata[KEY_W+TICK_W-1:KEY_W];
    assign in_key_wide = WIDE_W'(in_key);
    assign in_addr     = in_key_wide[IDX_W-1:0];
    assign in_range    = (32'(in_key) < 32'(KEY_COUNT));
    assign accept      = s_tvalid && s_tready;

    // read stage handshake
    logic p1_valid_reg;
    logic advance;

    assign advance  = !m_tvalid || m_tready;
    assign s_tready = !p1_valid_reg || advance;

    // read stage payload
    logic [KEY_W-1:0]  p1_key_reg;
    logic [IDX_W-1:0]  p1_addr_reg;
    logic              p1_press_reg;
    logic [TICK_W-1:0] p1_now_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
        end else if (s_tready) begin
            p1_valid_reg <= s_tvalid && in_range;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            p1_key_reg   <= in_key;
            p1_addr_reg  <= in_addr;
            p1_press_reg <= s_tuser;
            p1_now_reg   <= in_now;
        end
    end

    // write-back from the read stage, presses only
    logic              wr_en;
    logic [TICK_W-1:0] wr_tap;

    assign wr_en = p1_valid_reg && advance && p1_press_reg;

    // per-key memories and valid bits
    logic [TICK_W-1:0] press_mem [KEY_COUNT];
    logic [TICK_W-1:0] tap_mem   [KEY_COUNT];
    logic [KEY_COUNT-1:0] vld_reg;

    logic [TICK_W-1:0] rd_press_reg, rd_tap_reg;
    logic              rd_vld_reg;
    logic              fwd_hit_reg;
    logic [TICK_W-1:0] fwd_press_reg, fwd_tap_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            press_mem[p1_addr_reg] <= p1_now_reg;
            tap_mem[p1_addr_reg]   <= wr_tap;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            rd_press_reg <= press_mem[in_addr];
            rd_tap_reg   <= tap_mem[in_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (wr_en) begin
            vld_reg[p1_addr_reg] <= 1'b1;
        end
    end

    // valid bit and forwarding capture alongside the read
    always_ff @(posedge aclk) begin
        if (accept) begin
            rd_vld_reg    <= vld_reg[in_addr];
            fwd_hit_reg   <= wr_en && (p1_addr_reg == in_addr);
            fwd_press_reg <= p1_now_reg;
            fwd_tap_reg   <= wr_tap;
        end
    end

    // resolved per-key state
    logic [TICK_W-1:0] cur_press, cur_tap;

    always_comb begin
        if (fwd_hit_reg) begin
            cur_press = fwd_press_reg;
            cur_tap   = fwd_tap_reg;
        end else if (rd_vld_reg) begin
            cur_press = rd_press_reg;
            cur_tap   = rd_tap_reg;
        end else begin
            cur_press = '0;
            cur_tap   = '0;
        end
    end

    // classification
    logic [TICK_W-1:0]  since_tap, held;
    logic               is_double;
    kind_t              kind_next;
    logic [COUNT_W-1:0] count_next;
    logic [TICK_W-1:0]  dur_next;

    assign since_tap = p1_now_reg - cur_tap;
    assign held      = p1_now_reg - cur_press;
    assign is_double = (cur_tap != '0) && (since_tap < TICK_W'(dbl_win_reg));
    assign wr_tap    = is_double ? '0 : p1_now_reg;

    always_comb begin
        dur_next = '0;
        if (p1_press_reg) begin
            if (is_double) begin
                kind_next  = KIND_DOUBLE_TAP;
                count_next = COUNT_DOUBLE;
            end else begin
                kind_next  = KIND_KEY_DOWN;
                count_next = COUNT_SINGLE;
            end
        end else begin
            count_next = COUNT_NONE;
            if (held >= TICK_W'(hold_thr_reg)) begin
                kind_next = KIND_HOLD_RELEASE;
                dur_next  = held;
            end else if (held >= TICK_W'(long_thr_reg)) begin
                kind_next = KIND_LONG_TAP;
            end else if (held >= TICK_W'(tap_thr_reg)) begin
                kind_next = KIND_TAP;
            end else begin
                kind_next = KIND_KEY_UP;
            end
        end
    end

    // output register
    logic               m_valid_reg;
    kind_t              m_kind_reg;
    logic [KEY_W-1:0]   m_key_reg;
    logic [COUNT_W-1:0] m_count_reg;
    logic [TICK_W-1:0]  m_dur_reg;
    logic [TICK_W-1:0]  m_time_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= p1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && p1_valid_reg) begin
            m_kind_reg  <= kind_next;
            m_key_reg   <= p1_key_reg;
            m_count_reg <= count_next;
            m_dur_reg   <= dur_next;
            m_time_reg  <= p1_now_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_kind_reg;
    assign m_tdata  = {1'b0, m_time_reg, m_dur_reg, m_count_reg, m_key_reg};

endmodule

`default_nettype wire

FILE: tb/key_tap_press_classifier_tb.sv
// key_tap_press_classifier_tb: self-checking stream testbench for the key tap and press classifier
// drives key words and threshold writes, predicts each event word and compares it field by field
// depends on kpc_pkg and key_tap_press_classifier
`default_nettype none

module key_tap_press_classifier_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import kpc_pkg::*;

    // one key word as it enters the block
    typedef struct {
        logic [KEY_W-1:0]  key;
        logic              pressed;
        logic [TICK_W-1:0] now;
    } key_word_t;

    // one predicted event word
    typedef struct {
        kind_t              kind;
        logic [KEY_W-1:0]   key;
        logic [COUNT_W-1:0] count;
        logic [TICK_W-1:0]  dur;
        logic [TICK_W-1:0]  etime;
    } tap_event_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    wire logic             s_tready;
    logic [S_DATA_W-1:0]   s_tdata   = '0;
    logic                  s_tuser   = 1'b0;
    wire logic             m_tvalid;
    logic                  m_tready  = 1'b0;
    wire logic [M_DATA_W-1:0] m_tdata;
    wire logic [2:0]       m_tuser;
    logic                  cfg_valid = 1'b0;
    wire logic             cfg_ready;
    logic [CIDX_W-1:0]     cfg_index = '0;
    logic [THR_W-1:0]      cfg_data  = '0;

    key_tap_press_classifier uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #4 aclk = ~aclk;

    // predictor state: thresholds and per-key times
    logic [THR_W-1:0]  thr_reg  [4];
    logic [TICK_W-1:0] press_at [KEY_COUNT_DEF];
    logic [TICK_W-1:0] tap_at   [KEY_COUNT_DEF];

    key_word_t  pending_words[$];
    tap_event_t events_due[$];

    int  n_queued     = 0;
    int  n_accepted   = 0;
    int  n_results    = 0;
    int  n_writes     = 0;
    int  fault_count  = 0;
    int  gap_left     = 0;
    int  stall_left   = 0;
    bit  pace_on      = 1'b1;
    logic s_taken     = 1'b0;
    logic m_taken     = 1'b0;
    logic cfg_taken   = 1'b0;
    logic [TICK_W-1:0] gen_tick = '0;

    task automatic report_fault(input string what, input logic [31:0] got,
                                input logic [31:0] want);
        $display("mismatch at %0t: %s got %0h want %0h", $realtime, what, got, want);
        fault_count++;
    endtask

    // classify one key word and advance the per-key times
    function automatic tap_event_t classify_key_event(input logic [KEY_W-1:0] key,
                                                     input logic pressed,
                                                     input logic [TICK_W-1:0] now);
        tap_event_t ev;
        logic [TICK_W-1:0] last;
        logic [TICK_W-1:0] held;
        ev.key   = key;
        ev.etime = now;
        ev.count = COUNT_NONE;
        ev.dur   = '0;
        // every 5-bit index is below the key count, so no word is dropped
        if (pressed) begin
            last = tap_at[key];
            press_at[key] = now;
            // a recorded tap of zero means none, so a press at tick zero leaves nothing to pair with
            if (last != '0 && (now - last) < {16'b0, thr_reg[CFG_DBL_WIN]}) begin
                ev.kind = KIND_DOUBLE_TAP;
                ev.count = COUNT_DOUBLE;
                tap_at[key] = '0;
            end else begin
                ev.kind = KIND_KEY_DOWN;
                ev.count = COUNT_SINGLE;
                tap_at[key] = now;
            end
        end else begin
            // held time wraps modulo 2^32, from zero if the key was never pressed
            held = now - press_at[key];
            if (held >= {16'b0, thr_reg[CFG_HOLD_THR]}) begin
                ev.kind = KIND_HOLD_RELEASE;
                ev.dur = held;
            end else if (held >= {16'b0, thr_reg[CFG_LONG_THR]}) begin
                ev.kind = KIND_LONG_TAP;
            end else if (held >= {16'b0, thr_reg[CFG_TAP_THR]}) begin
                ev.kind = KIND_TAP;
            end else begin
                ev.kind = KIND_KEY_UP;
            end
        end
        return ev;
    endfunction

    // handshake capture, prediction and result checking
    always @(posedge aclk) begin : monitor
        tap_event_t want;
        s_taken   <= aresetn && s_tvalid && s_tready;
        m_taken   <= aresetn && m_tvalid && m_tready;
        cfg_taken <= aresetn && cfg_valid && cfg_ready;
        if (aresetn && s_tvalid && s_tready) begin
            events_due.push_back(classify_key_event(s_tdata[4:0], s_tuser, s_tdata[36:5]));
            n_accepted++;
        end
        if (aresetn && m_tvalid && m_tready) begin
            n_results++;
            if (events_due.size() == 0) begin
                report_fault("event word with none due", {29'b0, m_tuser}, '0);
            end else begin
                want = events_due.pop_front();
                if (m_tuser !== want.kind)
                    report_fault("event_kind", {29'b0, m_tuser}, {29'b0, want.kind});
                if (m_tdata[4:0] !== want.key)
                    report_fault("event_key", {27'b0, m_tdata[4:0]}, {27'b0, want.key});
                if (m_tdata[6:5] !== want.count)
                    report_fault("press_count", {30'b0, m_tdata[6:5]}, {30'b0, want.count});
                if (m_tdata[38:7] !== want.dur)
                    report_fault("duration_ticks", m_tdata[38:7], want.dur);
                if (m_tdata[70:39] !== want.etime)
                    report_fault("event_time", m_tdata[70:39], want.etime);
                if (m_tdata[71] !== 1'b0)
                    report_fault("tdata pad bit", {31'b0, m_tdata[71]}, '0);
            end
        end
    end

    // input driver: one word from the pending queue, then a random gap when pacing is on
    always @(negedge aclk) begin : driver
        key_word_t w;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= 1'b0;
            gap_left <= 0;
        end else if (s_tvalid && !s_taken) begin
            // hold the word until it is taken
        end else if (gap_left != 0) begin
            s_tvalid <= 1'b0;
            gap_left <= gap_left - 1;
        end else if (pending_words.size() != 0) begin
            w = pending_words.pop_front();
            s_tvalid <= 1'b1;
            s_tdata  <= {3'b0, w.now, w.key};
            s_tuser  <= w.pressed;
            gap_left <= pace_on ? int'($urandom_range(0, 15)) : 0;
        end else begin
            s_tvalid <= 1'b0;
        end
    end

    // result sink: random stall after each word taken when pacing is on
    always @(negedge aclk) begin : sink
        int st;
        st = stall_left;
        if (!aresetn) begin
            m_tready   <= 1'b0;
            stall_left <= 0;
        end else begin
            if (m_taken)
                st = pace_on ? int'($urandom_range(0, 15)) : 0;
            if (st != 0) begin
                m_tready   <= 1'b0;
                stall_left <= st - 1;
            end else begin
                m_tready   <= 1'b1;
                stall_left <= 0;
            end
        end
    end

    task automatic add_word(input logic [KEY_W-1:0] key, input logic pressed,
                            input logic [TICK_W-1:0] now);
        key_word_t w;
        w.key = key;
        w.pressed = pressed;
        w.now = now;
        pending_words.push_back(w);
        n_queued++;
    endtask

    task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [THR_W-1:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(negedge aclk); while (!cfg_taken);
        // indexes past the last register are ignored by the block
        if (idx <= CIDX_W'(CFG_HOLD_THR))
            thr_reg[idx] = val;
        n_writes++;
        cfg_valid <= 1'b0;
    endtask

    // wait until every word is taken and every event word has arrived
    task automatic drain();
        while (n_accepted != n_queued || events_due.size() != 0)
            @(negedge aclk);
        repeat (6) @(negedge aclk);
    endtask

    // a span close to a threshold, or well away from it
    function automatic logic [TICK_W-1:0] near_threshold(input logic [THR_W-1:0] thr);
        logic [TICK_W-1:0] t;
        t = {16'b0, thr};
        case ($urandom_range(0, 5))
            0: return t - 1;
            1: return t;
            2: return t + 1;
            3: return TICK_W'($urandom_range(0, thr));
            4: return TICK_W'($urandom_range(0, 70000));
            default: return t + TICK_W'($urandom_range(0, 40));
        endcase
    endfunction

    // mostly press/release pairs and press pairs on a few keys, some noise
    task automatic add_random_words(input int n);
        int added;
        int pick;
        logic [KEY_W-1:0] k;
        added = 0;
        while (added < n) begin
            pick = $urandom_range(0, 99);
            k = ($urandom_range(0, 3) == 0) ? KEY_W'($urandom_range(0, 31))
                                            : KEY_W'($urandom_range(0, 3));
            gen_tick = gen_tick + TICK_W'($urandom_range(0, 3000));
            if (pick < 50) begin
                add_word(k, 1'b1, gen_tick);
                gen_tick = gen_tick + near_threshold(thr_reg[$urandom_range(0, 3)]);
                add_word(k, 1'b0, gen_tick);
                added += 2;
            end else if (pick < 75) begin
                add_word(k, 1'b1, gen_tick);
                gen_tick = gen_tick + near_threshold(thr_reg[CFG_DBL_WIN]);
                add_word(k, 1'b1, gen_tick);
                added += 2;
            end else begin
                add_word(KEY_W'($urandom), 1'($urandom), $urandom);
                added += 1;
            end
        end
    endtask

    initial begin : limit
        #5_000_000;
        $display("timeout waiting for event words");
        $display("Some tests failed");
        $finish;
    end

    initial begin : stimulus
        thr_reg[CFG_TAP_THR]  = TAP_THR_RST;
        thr_reg[CFG_LONG_THR] = LONG_THR_RST;
        thr_reg[CFG_DBL_WIN]  = DBL_WIN_RST;
        thr_reg[CFG_HOLD_THR] = HOLD_THR_RST;
        foreach (press_at[i]) begin
            press_at[i] = '0;
            tap_at[i]   = '0;
        end
        gen_tick = $urandom;

        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed words at reset thresholds
        pace_on = 1'b1;
        // press at tick zero records no tap
        add_word(5'd0, 1'b1, 32'd0);
        add_word(5'd0, 1'b1, 32'd100);
        add_word(5'd0, 1'b0, 32'd150);
        add_word(5'd0, 1'b1, 32'd200);
        add_word(5'd0, 1'b0, 32'd500);
        add_word(5'd0, 1'b1, 32'd600);
        add_word(5'd0, 1'b0, 32'd1100);
        // elapsed exactly the window is not a double tap
        add_word(5'd0, 1'b1, 32'd1000);
        add_word(5'd0, 1'b0, 32'd2000);
        // release of a key never pressed measures from zero
        add_word(5'd31, 1'b0, 32'hFFFF_FFFF);
        // one tick short of each threshold
        add_word(5'd2, 1'b1, 32'd1000);
        add_word(5'd2, 1'b0, 32'd1299);
        add_word(5'd2, 1'b1, 32'd3000);
        add_word(5'd2, 1'b0, 32'd3499);
        add_word(5'd2, 1'b1, 32'd5000);
        add_word(5'd2, 1'b0, 32'd5999);
        // release and double tap across the tick wrap
        add_word(5'd30, 1'b1, 32'hFFFF_FF00);
        add_word(5'd30, 1'b0, 32'h0000_0010);
        add_word(5'd30, 1'b1, 32'h0000_0050);
        add_word(5'd1, 1'b1, 32'hFFFF_FFFF);
        add_word(5'd1, 1'b1, 32'h0000_0005);
        add_word(5'd17, 1'b1, 32'h7FFF_FFFF);
        add_word(5'd17, 1'b0, 32'h8000_0000);
        add_word(5'd21, 1'b1, 32'hAAAA_AAAA);
        add_word(5'd10, 1'b0, 32'h5555_5555);
        drain();

        // all thresholds zero, plus writes to unused indexes
        write_reg(CFG_TAP_THR, 16'h0000);
        write_reg(CFG_LONG_THR, 16'h0000);
        write_reg(CFG_DBL_WIN, 16'h0000);
        write_reg(CFG_HOLD_THR, 16'h0000);
        write_reg(8'hFF, 16'hFFFF);
        write_reg(8'h04, 16'h1234);
        pace_on = 1'b0;
        add_random_words(100);
        drain();

        // all thresholds at their maximum
        write_reg(CFG_TAP_THR, 16'hFFFF);
        write_reg(CFG_LONG_THR, 16'hFFFF);
        write_reg(CFG_DBL_WIN, 16'hFFFF);
        write_reg(CFG_HOLD_THR, 16'hFFFF);
        pace_on = 1'b1;
        add_random_words(100);
        drain();

        // small ordered thresholds
        write_reg(CFG_TAP_THR, 16'($urandom_range(0, 400)));
        write_reg(CFG_LONG_THR, 16'($urandom_range(400, 900)));
        write_reg(CFG_DBL_WIN, 16'($urandom_range(0, 2000)));
        write_reg(CFG_HOLD_THR, 16'($urandom_range(900, 2000)));
        pace_on = 1'b1;
        add_random_words(200);
        drain();

        // thresholds in reverse order, hold below tap
        write_reg(CFG_TAP_THR, 16'd5000);
        write_reg(CFG_LONG_THR, 16'd2000);
        write_reg(CFG_DBL_WIN, 16'($urandom));
        write_reg(CFG_HOLD_THR, 16'd100);
        pace_on = 1'b0;
        add_random_words(100);
        drain();

        // fully random thresholds and a stray index
        write_reg(CFG_TAP_THR, 16'($urandom));
        write_reg(CFG_LONG_THR, 16'($urandom));
        write_reg(CIDX_W'($urandom_range(4, 255)), 16'($urandom));
        write_reg(CFG_DBL_WIN, 16'($urandom));
        write_reg(CFG_HOLD_THR, 16'($urandom));
        pace_on = 1'b1;
        add_random_words(275);
        drain();

        $display("%0d key words sent, %0d event words checked", n_queued, n_results);
        $display("%0d register writes over six threshold settings, extremes included",
                 n_writes);
        if (fault_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
